### sv/rbt_pkg.sv
// Shared types, constants and filter table for the baud timing calculator.
package rbt_pkg;

  localparam logic [9:0] RATE_MIN = 10'd1;
  localparam logic [9:0] RATE_MAX = 10'd256;
  localparam logic [10:0] GAIN_MAX = 11'h7FF;
  localparam logic [7:0] MODE_LOW = 8'h4C;
  localparam logic [7:0] MODE_HIGH = 8'h0C;
  localparam logic [7:0] CODE_NONE = 8'hFF;
  localparam int NUM_W = 36;
  localparam int DEN_W = 20;
  localparam int CNT_W = 6;

  // floor(x / 1000) = (x * DRW_RECIP) >> 36, exact for x below 2^26
  localparam logic [26:0] DRW_RECIP = 27'd68719477;
  // 2^18 = d * Q + 19 for d = 125 and d = 375
  localparam logic [11:0] NCO_Q_LO = 12'd2097;
  localparam logic [11:0] NCO_Q_HI = 12'd699;
  // floor(x / d) = (x * recip) >> 28, exact for x below 2^20
  localparam logic [21:0] NCO_RECIP_LO = 22'd2147484;
  localparam logic [21:0] NCO_RECIP_HI = 22'd715828;

  localparam logic [12:0] BW_TABLE [8] = '{
    13'd322, 13'd3355, 13'd3618, 13'd4202, 13'd4684, 13'd5188, 13'd5770, 13'd6207
  };
  localparam logic [7:0] BW_CODE [8] = '{
    8'h26, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E
  };

  typedef struct packed {
    logic       ok;
    logic [8:0] rate;
    logic       dev_hi;
    logic       slow;
    logic [7:0] mode;
    logic [7:0] dev_code;
    logic [7:0] code;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RECIP, S_RECIP_MUL, S_OSR_GO, S_OSR_WT,
    S_MUL, S_GAIN_GO, S_GAIN_WT, S_DONE
  } state_t;

  typedef struct packed {
    logic                     start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

endpackage

### sv/rbt_front.sv
// Front end: range check, deviation, mode and IF filter selection.
module rbt_front (
  input  logic [9:0]        rate_kbps,
  output rbt_pkg::item_t    item
);

  logic [13:0] need;
  logic [7:0]  code;
  logic        ok;
  logic        dev_hi;

  assign ok = (rate_kbps >= rbt_pkg::RATE_MIN) && (rate_kbps <= rbt_pkg::RATE_MAX);
  assign dev_hi = rate_kbps > 10'd10;
  assign need = 14'((dev_hi ? 14'd300 : 14'd30) + 14'(rate_kbps)) * 14'd10;

  always_comb begin
    code = rbt_pkg::CODE_NONE;
    for (int i = 7; i >= 0; i--) begin
      if (14'(rbt_pkg::BW_TABLE[i]) >= need) code = rbt_pkg::BW_CODE[i];
    end
  end

  always_comb begin
    item = '0;
    if (ok) begin
      item.ok = 1'b1;
      item.rate = rate_kbps[8:0];
      item.dev_hi = dev_hi;
      item.slow = rate_kbps < 10'd30;
      item.mode = (rate_kbps < 10'd30) ? rbt_pkg::MODE_LOW : rbt_pkg::MODE_HIGH;
      item.dev_code = dev_hi ? 8'd240 : 8'd24;
      item.code = code;
    end
  end

endmodule

### sv/rbt_queue.sv
// Two-entry queue between front and back end.
module rbt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rbt_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output rbt_pkg::item_t pop_item
);

  rbt_pkg::item_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign pop_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

### sv/rbt_div.sv
// Restoring divider, one quotient bit per cycle.
module rbt_div (
  input  logic                         clk,
  input  logic                         rst,
  input  rbt_pkg::div_req_t            req,
  output logic                         busy,
  output logic                         done,
  output logic [rbt_pkg::NUM_W-1:0]    quo
);

  logic [rbt_pkg::DEN_W-1:0] rem;
  logic [rbt_pkg::DEN_W-1:0] den;
  logic [rbt_pkg::CNT_W-1:0] cnt;
  logic [rbt_pkg::DEN_W:0]   trial;
  logic                      ge;

  assign trial = {rem, quo[rbt_pkg::NUM_W-1]};
  assign ge = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= ge ? rbt_pkg::DEN_W'(trial - {1'b0, den}) : trial[rbt_pkg::DEN_W-1:0];
      quo <= {quo[rbt_pkg::NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= rbt_pkg::CNT_W'(rbt_pkg::NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == rbt_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/rbt_back.sv
// Back end: sequences the divisions and holds the result register.
module rbt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  rbt_pkg::item_t       q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 accepted,
  output logic [7:0]           modulation_mode,
  output logic [7:0]           deviation_code,
  output logic [15:0]          data_rate_word,
  output logic [7:0]           if_filter_code,
  output logic [11:0]          oversampling_ratio,
  output logic [17:0]          nco_offset,
  output logic [10:0]          recovery_gain
);

  rbt_pkg::state_t  state, state_next;
  rbt_pkg::item_t   item;
  rbt_pkg::div_req_t req;
  logic             div_busy;
  logic             div_done;
  logic [rbt_pkg::NUM_W-1:0] quo;
  logic [15:0] drw;
  logic [11:0] osr;
  logic [17:0] nco;
  logic [10:0] gain;
  logic [19:0] gden;
  logic [10:0] div_c;
  logic [15:0] rate_sh;
  logic        emit;
  logic [25:0] drw_x;
  logic [19:0] nco_x;
  logic [27:0] nco_base;
  logic [52:0] drw_prod;
  logic [41:0] nco_prod;
  logic [27:0] nco_sum;

  rbt_div u_div (
    .clk (clk), .rst (rst), .req (req), .busy (div_busy), .done (div_done), .quo (quo)
  );

  assign div_c = item.code[7] ? 11'd1500 : 11'd500;
  assign rate_sh = 16'({7'd0, item.rate} << item.code[6:4]);
  assign emit = (state == rbt_pkg::S_DONE) && (!out_valid || out_ready);

  assign drw_prod = 53'(drw_x) * 53'(rbt_pkg::DRW_RECIP);
  assign nco_prod = 42'(nco_x) *
                    42'(item.code[7] ? rbt_pkg::NCO_RECIP_HI : rbt_pkg::NCO_RECIP_LO);
  assign nco_sum = nco_base + {14'd0, nco_prod[41:28]};

  always_comb begin
    state_next = state;
    case (state)
      rbt_pkg::S_IDLE:      if (q_valid) state_next = q_item.ok ? rbt_pkg::S_RECIP
                                                                : rbt_pkg::S_DONE;
      rbt_pkg::S_RECIP:     state_next = rbt_pkg::S_RECIP_MUL;
      rbt_pkg::S_RECIP_MUL: state_next = rbt_pkg::S_OSR_GO;
      rbt_pkg::S_OSR_GO:    state_next = rbt_pkg::S_OSR_WT;
      rbt_pkg::S_OSR_WT:    if (div_done) state_next = rbt_pkg::S_MUL;
      rbt_pkg::S_MUL:       state_next = rbt_pkg::S_GAIN_GO;
      rbt_pkg::S_GAIN_GO:   state_next = (gden == '0) ? rbt_pkg::S_DONE : rbt_pkg::S_GAIN_WT;
      rbt_pkg::S_GAIN_WT:   if (div_done) state_next = rbt_pkg::S_DONE;
      rbt_pkg::S_DONE:      if (emit) state_next = rbt_pkg::S_IDLE;
      default:              state_next = rbt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req = '0;
    q_pop = (state == rbt_pkg::S_IDLE) && q_valid;
    case (state)
      rbt_pkg::S_OSR_GO: begin
        req.start = 1'b1;
        req.num = 36'(div_c) * 36'd16 + 36'(rate_sh);
        req.den = {3'd0, rate_sh, 1'b0};
      end
      rbt_pkg::S_GAIN_GO: begin
        req.start = gden != '0;
        req.num = 36'(item.rate) * 36'd65535;
        req.den = gden;
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_item;
      drw <= '0;
      osr <= '0;
      nco <= '0;
      gain <= '0;
    end
    // ceiling of rate * 2^(e+18) / d split as rate_sh * Q + ceiling of 19 * rate_sh / d
    if (state == rbt_pkg::S_RECIP) begin
      drw_x <= (item.slow ? (26'(item.rate) << 21) : (26'(item.rate) << 16)) + 26'd500;
      nco_base <= 28'(rate_sh) *
                  28'(item.code[7] ? rbt_pkg::NCO_Q_HI : rbt_pkg::NCO_Q_LO);
      nco_x <= 20'(rate_sh) * 20'd19 + (item.code[7] ? 20'd374 : 20'd124);
    end
    if (state == rbt_pkg::S_RECIP_MUL) begin
      drw <= drw_prod[51:36];
      nco <= nco_sum[17:0];
    end
    if (div_done) begin
      case (state)
        rbt_pkg::S_OSR_WT: osr <= quo[11:0];
        rbt_pkg::S_GAIN_WT: gain <= (quo > 36'd2045) ? rbt_pkg::GAIN_MAX : 11'(quo + 36'd2);
        default: ;
      endcase
    end
    if (state == rbt_pkg::S_MUL) gden <= 20'(osr) * (item.dev_hi ? 20'd150 : 20'd15);
    if (state == rbt_pkg::S_GAIN_GO && gden == '0) gain <= rbt_pkg::GAIN_MAX;
    if (emit) begin
      accepted <= item.ok;
      modulation_mode <= item.mode;
      deviation_code <= item.dev_code;
      data_rate_word <= drw;
      if_filter_code <= item.code;
      oversampling_ratio <= osr;
      nco_offset <= nco;
      recovery_gain <= gain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbt_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !div_busy) else $error("divider restarted while busy");
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |-> (recovery_gain == '0 && nco_offset == '0 &&
    data_rate_word == '0 && if_filter_code == '0))
    else $error("rejected transaction carries data");
  a_gain_floor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> recovery_gain >= 11'd2) else $error("gain below two");

endmodule

### sv/radio_baud_timing_calc_unit.sv
// Top level of the baud timing calculator.
// Each accepted rate runs two divisions (oversampling ratio, gain) in one shared
//   divider; a rejected rate skips both divisions and goes straight to the result.
// The back end works on one rate at a time and pops the next rate only when idle.
// Input accepted while the two-entry queue has room; result held until taken.
// Synchronous active-high reset empties the queue and clears the output valid.
module radio_baud_timing_calc_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  rate_kbps,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic [7:0]  modulation_mode,
  output logic [7:0]  deviation_code,
  output logic [15:0] data_rate_word,
  output logic [7:0]  if_filter_code,
  output logic [11:0] oversampling_ratio,
  output logic [17:0] nco_offset,
  output logic [10:0] recovery_gain
);

  rbt_pkg::item_t f_item;
  rbt_pkg::item_t q_item;
  logic q_full, q_valid, q_pop;

  assign in_ready = !q_full;

  rbt_front u_front (.rate_kbps (rate_kbps), .item (f_item));

  rbt_queue u_queue (
    .clk (clk), .rst (rst), .push (in_valid && in_ready), .push_item (f_item),
    .full (q_full), .pop (q_pop), .not_empty (q_valid), .pop_item (q_item)
  );

  rbt_back u_back (
    .clk (clk), .rst (rst), .q_valid (q_valid), .q_item (q_item), .q_pop (q_pop),
    .out_valid (out_valid), .out_ready (out_ready), .accepted (accepted),
    .modulation_mode (modulation_mode), .deviation_code (deviation_code),
    .data_rate_word (data_rate_word), .if_filter_code (if_filter_code),
    .oversampling_ratio (oversampling_ratio), .nco_offset (nco_offset),
    .recovery_gain (recovery_gain)
  );

endmodule
